[rtl/bss_pkg.sv]
// Shared types and constants for the button state sync sender.
// No dependencies; imported by the core, the top level and the checker.
`default_nettype none

package bss_pkg;

  localparam int unsigned BTN_W      = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned IN_DATA_W  = 32;  // 26 used bits padded to bytes
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;  // 12 used bits padded to bytes

  localparam logic [MS_W-1:0] RESEND_INTERVAL_RST = 16'd1000;

  typedef enum logic [1:0] {
    FUNC_BUTTON = 2'd0,
    FUNC_RADIO  = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [BTN_W-1:0] buttons;
    logic             max_retries_hit;
    logic             send_done;
    logic [MS_W-1:0]  elapsed_ms;
  } bss_item_t;

  typedef struct packed {
    logic             send;
    logic [BTN_W-1:0] payload;
    logic             flush_tx;
    logic             clear_irq;
    logic             led_on;
  } bss_result_t;

endpackage

`default_nettype wire

[rtl/bss_core.sv]
// Sync state registers and the per-event update logic.
// Depends on bss_pkg. State advances only when step_i is high.
`default_nettype none

module bss_core import bss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire bss_item_t   item_i,
  input  wire logic        cfg_we_i,
  input  wire logic [MS_W-1:0] cfg_data_i,
  output bss_result_t      result_o
);

  logic [MS_W-1:0]  interval_q;
  logic [BTN_W-1:0] local_q, local_d;
  logic [BTN_W-1:0] inflight_q, inflight_d;
  logic [BTN_W-1:0] acked_q, acked_d;
  logic             ever_q, ever_d;
  logic             busy_q, busy_d;
  logic [MS_W-1:0]  count_q, count_d;
  logic             led_q, led_d;

  // Busy after any ack/flush of this event, before a new send.
  logic             busy_mid;
  logic             want_send;

  always_comb begin
    local_d    = local_q;
    inflight_d = inflight_q;
    acked_d    = acked_q;
    ever_d     = ever_q;
    busy_mid   = busy_q;
    count_d    = count_q;
    led_d      = led_q;
    want_send  = 1'b0;
    result_o   = '0;

    case (item_i.func)
      FUNC_BUTTON: begin
        local_d   = item_i.buttons;
        want_send = !ever_q || (item_i.buttons != acked_q);
        led_d     = (item_i.buttons != '0);
      end
      FUNC_RADIO: begin
        if (item_i.max_retries_hit) begin
          result_o.flush_tx = 1'b1;
          busy_mid          = 1'b0;
        end else if (item_i.send_done) begin
          ever_d   = 1'b1;
          acked_d  = inflight_q;
          busy_mid = 1'b0;
        end
        result_o.clear_irq = 1'b1;
        want_send = !ever_d || (local_q != acked_d);
      end
      FUNC_TICK: begin
        if (count_q <= item_i.elapsed_ms) begin
          want_send = 1'b1;
          count_d   = interval_q;
        end else begin
          count_d = count_q - item_i.elapsed_ms;
        end
      end
      default: ;
    endcase

    busy_d = busy_mid;
    if (want_send && !busy_mid) begin
      busy_d           = 1'b1;
      inflight_d       = local_d;
      result_o.send    = 1'b1;
      result_o.payload = local_d;
    end
    result_o.led_on = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= RESEND_INTERVAL_RST;
    end else if (cfg_we_i) begin
      interval_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q    <= '0;
      inflight_q <= '0;
      acked_q    <= '0;
      ever_q     <= 1'b0;
      busy_q     <= 1'b0;
      count_q    <= RESEND_INTERVAL_RST;
      led_q      <= 1'b0;
    end else if (step_i) begin
      local_q    <= local_d;
      inflight_q <= inflight_d;
      acked_q    <= acked_d;
      ever_q     <= ever_d;
      busy_q     <= busy_d;
      count_q    <= count_d;
      led_q      <= led_d;
    end
  end

endmodule

`default_nettype wire

[rtl/button_state_sync_sender_top.sv]
// Button state sync sender: input register, sync core, result register.
// Depends on bss_pkg and bss_core.
`default_nettype none

// Keeps a remote receiver's copy of an 8-bit button bitmap in step with the
// local buttons over an acknowledged stop-and-wait radio link. Each request
// on the slave stream is one event (tuser selects button change, radio event
// or timer tick) and yields exactly one result on the master stream, telling
// the radio driver whether to send (and what), whether to flush the transmit
// queue and whether to clear the interrupt flags, plus the LED level.
// Timing: a request is captured in an input register, evaluated by the core
// and lands in the result register once that register is free or being read,
// from where the result is offered on the master stream. One request per
// cycle is sustained as long as the master side keeps taking results; the
// input register refills while a finished result waits. Back-pressure from
// m_axis_tready reaches s_axis_tready in the same cycle.
// resend_interval (reset 1000 ms) is written over the cfg channel; the user
// writes it only while the block is idle, which the block does not enforce.
// A write takes effect at the next countdown reload.

module button_state_sync_sender_top import bss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // event requests
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // [7:0] buttons, [8] max_retries_hit, [9] send_done, [25:10] elapsed_ms
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] func
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  // results
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [0] send, [8:1] payload, [9] flush_tx, [10] clear_irq, [11] led_on
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  // resend_interval writes
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [MS_W-1:0]       cfg_data_i
);

  // input register
  logic      in_valid_q;
  bss_item_t in_item_q;
  bss_item_t in_item_d;

  // result register
  logic        out_valid_q;
  bss_result_t out_q;
  bss_result_t core_res;

  logic advance;   // input register moves into the result register
  logic take_in;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_item_d.func            = func_e'(s_axis_tuser);
    in_item_d.buttons         = s_axis_tdata[7:0];
    in_item_d.max_retries_hit = s_axis_tdata[8];
    in_item_d.send_done       = s_axis_tdata[9];
    in_item_d.elapsed_ms      = s_axis_tdata[25:10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_item_q <= in_item_d;
    end
  end

  bss_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_item_q),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.led_on, out_q.clear_irq, out_q.flush_tx,
                          out_q.payload, out_q.send};

endmodule

`default_nettype wire

[rtl/bss_chk.sv]
// Port-level checker for button_state_sync_sender_top, bound to it below.
// Depends on bss_pkg.
`default_nettype none

module bss_chk import bss_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no send means an empty payload
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == '0)
    else $error("payload without send");

  // flush only comes from a radio event, which always clears the irq
  a_flush_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[10])
    else $error("flush without irq clear");

  // with the result register empty the block must take a request
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind button_state_sync_sender_top bss_chk u_bss_chk (.*);

`default_nettype wire
